// ===== rtl/cwst_pkg.sv =====
package cwst_pkg;

   typedef struct packed {
      logic [7:0] in_char;
      logic       message_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       char_valid;
      logic       run_last;
      logic       message_end;
   } rsp_type;

   // results of one input transaction: count is 0, 1 or 2
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } dec_type;

   localparam logic [7:0] CHAR_HASH      = 8'h23;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_NINE      = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F   = 8'h46;
   localparam logic [7:0] CHAR_UPPER_Z   = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z   = 8'h7A;

   localparam int QUEUE_DEPTH = 4;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic is_hex_digit(input logic [7:0] c);
      return is_digit(c) || ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_F));
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
             ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
   endfunction

endpackage

// ===== rtl/control_word_space_trimmer_core.sv =====
// each accepted transaction's results are registered into the result queue; rsp_ shows the queue head
// throughput: one transaction per cycle while req_ready is high; a kept space adds one extra result on rsp_
// four-entry result queue, one result out per cycle while rsp_ready is high; req_ready low under two free entries
// reset: synchronous, active high; clears the scan mode to plain text and empties the queue
module control_word_space_trimmer_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cwst_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cwst_pkg::rsp_type rsp_data
);

   logic              accept;
   logic              space_ok;
   cwst_pkg::dec_type dec;

   assign req_ready = space_ok;
   assign accept    = req_valid & space_ok;

   cwst_decode u_decode (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .dec    (dec)
   );

   cwst_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .dec       (dec),
      .space_ok  (space_ok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/cwst_decode.sv =====
module cwst_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  cwst_pkg::req_type req,
   output cwst_pkg::dec_type dec
);

   localparam logic [2:0] MODE_PLAIN   = 3'd0;
   localparam logic [2:0] MODE_NAME    = 3'd1;
   localparam logic [2:0] MODE_HEX     = 3'd2;
   localparam logic [2:0] MODE_DEC     = 3'd3;
   localparam logic [2:0] MODE_SP_NONE = 3'd4;
   localparam logic [2:0] MODE_SP_HEX  = 3'd5;
   localparam logic [2:0] MODE_SP_DEC  = 3'd6;

   logic [2:0] mode_ff;
   logic [2:0] mode_in;
   logic [2:0] mode_next;
   logic       keep_space;
   logic       emit_char;
   logic [7:0] c;
   logic       last;

   assign c    = req.in_char;
   assign last = req.message_last;

   always_comb begin
      keep_space = 1'b0;
      emit_char  = 1'b1;
      mode_next  = (c == cwst_pkg::CHAR_BACKSLASH) ? MODE_NAME : MODE_PLAIN;
      case (mode_ff)
         MODE_NAME: begin
            if (cwst_pkg::is_letter(c)) begin
               mode_next = MODE_NAME;
            end else if (c == cwst_pkg::CHAR_HASH) begin
               mode_next = MODE_HEX;
            end else if (cwst_pkg::is_digit(c)) begin
               mode_next = MODE_DEC;
            end else if (c == cwst_pkg::CHAR_SPACE) begin
               emit_char = 1'b0;
               mode_next = MODE_SP_NONE;
            end
         end
         MODE_HEX: begin
            if (cwst_pkg::is_hex_digit(c)) begin
               mode_next = MODE_HEX;
            end else if (c == cwst_pkg::CHAR_SPACE) begin
               emit_char = 1'b0;
               mode_next = MODE_SP_HEX;
            end
         end
         MODE_DEC: begin
            if (cwst_pkg::is_digit(c)) begin
               mode_next = MODE_DEC;
            end else if (c == cwst_pkg::CHAR_SPACE) begin
               emit_char = 1'b0;
               mode_next = MODE_SP_DEC;
            end
         end
         MODE_SP_NONE: begin
            keep_space = (c != cwst_pkg::CHAR_BACKSLASH) && (c != cwst_pkg::CHAR_NUL);
         end
         MODE_SP_HEX: begin
            keep_space = cwst_pkg::is_hex_digit(c);
         end
         MODE_SP_DEC: begin
            keep_space = cwst_pkg::is_digit(c);
         end
         default: begin
            keep_space = 1'b0;
         end
      endcase
      if (last) begin
         mode_next = MODE_PLAIN;
      end
   end

   always_comb begin
      dec.first.out_char     = keep_space ? cwst_pkg::CHAR_SPACE : (emit_char ? c : 8'h00);
      dec.first.char_valid   = keep_space | emit_char;
      dec.first.run_last     = ~keep_space;
      dec.first.message_end  = ~keep_space & last;
      dec.second.out_char    = c;
      dec.second.char_valid  = 1'b1;
      dec.second.run_last    = 1'b1;
      dec.second.message_end = last;
      if (keep_space) begin
         dec.count = 2'd2;
      end else if (emit_char || last) begin
         dec.count = 2'd1;
      end else begin
         dec.count = 2'd0;
      end
   end

   assign mode_in = accept ? mode_next : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PLAIN;
      end else begin
         mode_ff <= mode_in;
      end
   end

   a_last_clears_mode: assert property (@(posedge clock) disable iff (reset)
      (accept && req.message_last) |=> (mode_ff == MODE_PLAIN))
      else $error("mode not cleared after message end");

   a_space_held_drops: assert property (@(posedge clock) disable iff (reset)
      (mode_next == MODE_SP_NONE || mode_next == MODE_SP_HEX || mode_next == MODE_SP_DEC)
      |-> (dec.count == 2'd0))
      else $error("held space produced a result");

endmodule

// ===== rtl/cwst_queue.sv =====
module cwst_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cwst_pkg::dec_type dec,
   output logic              space_ok,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cwst_pkg::rsp_type rsp_data
);

   localparam int PTR_W = $clog2(cwst_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(cwst_pkg::QUEUE_DEPTH + 1);

   cwst_pkg::rsp_type entry_ff [cwst_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [1:0]        n_push;
   logic              pop;

   assign n_push    = push ? dec.count : 2'd0;
   assign pop       = rsp_valid & rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign space_ok  = (count_ff <= CNT_W'(cwst_pkg::QUEUE_DEPTH - 2));

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(n_push);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + CNT_W'(n_push) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         entry_ff[wr_ptr_ff] <= dec.first;
      end
      if (n_push == 2'd2) begin
         entry_ff[wr_ptr_ff + PTR_W'(1)] <= dec.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(cwst_pkg::QUEUE_DEPTH))
      else $error("result queue overflow");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push |-> space_ok)
      else $error("transaction accepted without queue room");

   a_ptr_count_agree: assert property (@(posedge clock) disable iff (reset)
      (count_ff != CNT_W'(cwst_pkg::QUEUE_DEPTH)) |->
      (PTR_W'(wr_ptr_ff - rd_ptr_ff) == PTR_W'(count_ff)))
      else $error("queue pointers and count disagree");

endmodule
